@@ src/lcal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared types and codes of the binary-lifting LCA engine.
// ----------------------------------------------------------------------------
package lcal_pkg;

  localparam int OP_W   = 2;
  localparam int NODE_W = 10;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NODE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTB = 2'd3;

  localparam logic [IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROOT_NODE  = 2'd1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [4:0] {
    U_IDLE, U_DISP, U_ADD, U_BCHK, U_CLR, U_SEED, U_POP, U_CUR, U_DEP,
    U_EDGE, U_EDGE2, U_RCHK, U_LRD1, U_LRD2, U_LWR, U_BDONE, U_QCHK,
    U_QRA, U_QRB, U_QDA, U_QDB, U_QSWAP, U_LIFT, U_LIFTW, U_TEST,
    U_JRU, U_JRV, U_JCMP, U_PAR, U_PARW, U_FIN
  } uop_e;

  typedef struct packed {
    uop_e uop;
    logic take;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic ready;
    logic node_bad;
    logic root_bad;
    logic v_last;
    logic q_empty;
    logic e_done;
    logic edge_hit;
    logic p_ok;
    logic lvl_done;
    logic one_level;
    logic q_unreached;
    logic diff_bit;
    logic k_top;
    logic k_zero;
    logic u_eq_w;
  } dp_flags_t;

endpackage
`default_nettype wire

@@ src/lcal_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcal_if
// Valid/ready channels: input items, result items, register writes.
// ----------------------------------------------------------------------------
interface lcal_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcal_pkg::OP_W-1:0]   operation;
  logic [lcal_pkg::NODE_W-1:0] node_a;
  logic [lcal_pkg::NODE_W-1:0] node_b;
  modport source (output valid, operation, node_a, node_b, input ready);
  modport sink (input valid, operation, node_a, node_b, output ready);
endinterface

interface lcal_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcal_pkg::NODE_W-1:0] ancestor;
  logic [lcal_pkg::STAT_W-1:0] status;
  modport source (output valid, ancestor, status, input ready);
  modport sink (input valid, ancestor, status, output ready);
endinterface

interface lcal_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lcal_pkg::IDX_W-1:0] index;
  logic [lcal_pkg::CNT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/lcal_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcal_ctrl
// Sequencer: walks add, build and query micro-steps from datapath flags.
// ----------------------------------------------------------------------------
module lcal_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  lcal_pkg::dp_flags_t  flags_i,
  output lcal_pkg::dp_cmd_t    cmd_o
);
  import lcal_pkg::*;

  localparam logic [4:0] S_IDLE  = U_IDLE;
  localparam logic [4:0] S_DISP  = U_DISP;
  localparam logic [4:0] S_ADD   = U_ADD;
  localparam logic [4:0] S_BCHK  = U_BCHK;
  localparam logic [4:0] S_CLR   = U_CLR;
  localparam logic [4:0] S_SEED  = U_SEED;
  localparam logic [4:0] S_POP   = U_POP;
  localparam logic [4:0] S_CUR   = U_CUR;
  localparam logic [4:0] S_DEP   = U_DEP;
  localparam logic [4:0] S_EDGE  = U_EDGE;
  localparam logic [4:0] S_EDGE2 = U_EDGE2;
  localparam logic [4:0] S_RCHK  = U_RCHK;
  localparam logic [4:0] S_LRD1  = U_LRD1;
  localparam logic [4:0] S_LRD2  = U_LRD2;
  localparam logic [4:0] S_LWR   = U_LWR;
  localparam logic [4:0] S_BDONE = U_BDONE;
  localparam logic [4:0] S_QCHK  = U_QCHK;
  localparam logic [4:0] S_QRA   = U_QRA;
  localparam logic [4:0] S_QRB   = U_QRB;
  localparam logic [4:0] S_QDA   = U_QDA;
  localparam logic [4:0] S_QDB   = U_QDB;
  localparam logic [4:0] S_QSWAP = U_QSWAP;
  localparam logic [4:0] S_LIFT  = U_LIFT;
  localparam logic [4:0] S_LIFTW = U_LIFTW;
  localparam logic [4:0] S_TEST  = U_TEST;
  localparam logic [4:0] S_JRU   = U_JRU;
  localparam logic [4:0] S_JRV   = U_JRV;
  localparam logic [4:0] S_JCMP  = U_JCMP;
  localparam logic [4:0] S_PAR   = U_PAR;
  localparam logic [4:0] S_PARW  = U_PARW;
  localparam logic [4:0] S_FIN   = U_FIN;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       take, load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign take        = in_ready_o && in_valid_i;
  assign load        = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.uop  = uop_e'(state_q);
  assign cmd_o.take = take;
  assign cmd_o.load = load;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (take) state_d = S_DISP;
      S_DISP: begin
        case (flags_i.op)
          OP_ADD:   state_d = S_ADD;
          OP_BUILD: state_d = S_BCHK;
          OP_QUERY: state_d = S_QCHK;
          default:  state_d = S_FIN;
        endcase
      end
      S_ADD:   state_d = S_FIN;
      S_BCHK:  state_d = flags_i.root_bad ? S_FIN : S_CLR;
      S_CLR:   if (flags_i.v_last) state_d = S_SEED;
      S_SEED:  state_d = S_POP;
      S_POP: begin
        if (!flags_i.q_empty) state_d = S_CUR;
        else state_d = flags_i.one_level ? S_BDONE : S_LRD1;
      end
      S_CUR:   state_d = S_DEP;
      S_DEP:   state_d = S_EDGE;
      S_EDGE:  state_d = flags_i.e_done ? S_POP : S_EDGE2;
      S_EDGE2: state_d = flags_i.edge_hit ? S_RCHK : S_EDGE;
      S_RCHK:  state_d = S_EDGE;
      S_LRD1:  state_d = S_LRD2;
      S_LRD2: begin
        if (flags_i.p_ok) state_d = S_LWR;
        else state_d = flags_i.lvl_done ? S_BDONE : S_LRD1;
      end
      S_LWR:   state_d = flags_i.lvl_done ? S_BDONE : S_LRD1;
      S_BDONE: state_d = S_FIN;
      S_QCHK:  state_d = (!flags_i.ready || flags_i.node_bad) ? S_FIN : S_QRA;
      S_QRA:   state_d = S_QRB;
      S_QRB:   state_d = S_QDA;
      S_QDA:   state_d = flags_i.q_unreached ? S_FIN : S_QDB;
      S_QDB:   state_d = S_QSWAP;
      S_QSWAP: state_d = S_LIFT;
      S_LIFT: begin
        if (flags_i.diff_bit) state_d = S_LIFTW;
        else if (flags_i.k_top) state_d = S_TEST;
      end
      S_LIFTW: state_d = flags_i.k_top ? S_TEST : S_LIFT;
      S_TEST:  state_d = flags_i.u_eq_w ? S_FIN : S_JRU;
      S_JRU:   state_d = S_JRV;
      S_JRV:   state_d = S_JCMP;
      S_JCMP:  state_d = flags_i.k_zero ? S_PAR : S_JRU;
      S_PAR:   state_d = S_PARW;
      S_PARW:  state_d = S_FIN;
      S_FIN:   if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting item");
  a_take_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == S_DISP))
    else $error("accepted item not dispatched");
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !load) |=> (state_q == S_FIN))
    else $error("result dropped while output busy");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not valid");
`endif

endmodule
`default_nettype wire

@@ src/lcal_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcal_dp
// Datapath: edge store, walk queue, depth, reached and ancestor memories.
// ----------------------------------------------------------------------------
module lcal_dp #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  lcal_pkg::dp_cmd_t             cmd_i,
  output lcal_pkg::dp_flags_t           flags_o,
  input  wire [lcal_pkg::OP_W-1:0]      operation_i,
  input  wire [lcal_pkg::NODE_W-1:0]    node_a_i,
  input  wire [lcal_pkg::NODE_W-1:0]    node_b_i,
  input  wire                           cfg_we_i,
  input  wire [lcal_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire [lcal_pkg::CNT_W-1:0]     cfg_data_i,
  output logic [lcal_pkg::NODE_W-1:0]   ancestor_o,
  output logic [lcal_pkg::STAT_W-1:0]   status_o
);
  import lcal_pkg::*;

  localparam int NW       = $clog2(MAX_NODES);
  localparam int CW       = $clog2(MAX_NODES + 1);
  localparam int KW       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int XW       = ((CW > CNT_W) ? CW : CNT_W) + 1;
  localparam int EDGE_CAP = MAX_NODES - 1;
  localparam int ANC_D    = LIFT_LEVELS * (2 ** NW);
  localparam logic [CW-1:0] NO_ANC = CW'(MAX_NODES);

  // registers
  logic [CNT_W-1:0]  ncount_q;
  logic [NODE_W-1:0] root_q;
  logic [NW-1:0]     edge_total_q;
  logic              ready_q;
  logic [OP_W-1:0]   op_q;
  logic [NODE_W-1:0] a_q, b_q;
  logic [NW-1:0]     cur_q, cdep_q, other_q, v_q, u_q, w_q, diff_q, da_q;
  logic [CW-1:0]     pu_q;
  logic [NW-1:0]     e_q;
  logic [CW-1:0]     head_q, tail_q;
  logic [KW-1:0]     k_q;
  logic              ok_q;
  logic [NODE_W-1:0] res_anc_q;
  logic [STAT_W-1:0] res_st_q;

  // memories
  logic [2*NW-1:0] edge_mem [EDGE_CAP];
  logic [NW-1:0]   queue_mem [MAX_NODES];
  logic [NW-1:0]   depth_mem [MAX_NODES];
  logic            reached_mem [MAX_NODES];
  logic [CW-1:0]   anc_mem [ANC_D];

  logic [2*NW-1:0]   edge_rd;
  logic [NW-1:0]     queue_rd, depth_rd;
  logic              reached_rd;
  logic [CW-1:0]     anc_rd;

  logic              edge_we, queue_we, depth_we, reached_we, anc_we;
  logic [NW-1:0]     queue_wa, depth_wa, reached_wa, queue_ra, depth_ra, reached_ra;
  logic [NW-1:0]     queue_wd, depth_wd;
  logic              reached_wd;
  logic [KW+NW-1:0]  anc_wa, anc_ra;
  logic [CW-1:0]     anc_wd;

  logic [CW-1:0]     n_act;
  logic [NW-1:0]     node_a, node_b, root;
  logic [NW-1:0]     ea, eb, other;
  logic              hit_any, p_ok, adv, k_last_b;
  logic [KW-1:0]     k_next;

  assign node_a = NW'(a_q);
  assign node_b = NW'(b_q);
  assign root   = NW'(root_q);

  always_comb begin
    if (ncount_q == '0) n_act = CW'(1);
    else if (XW'(ncount_q) > XW'(MAX_NODES)) n_act = CW'(MAX_NODES);
    else n_act = CW'(ncount_q);
  end

  assign ea = edge_rd[2*NW-1:NW];
  assign eb = edge_rd[NW-1:0];
  always_comb begin
    hit_any = 1'b1;
    other   = eb;
    if (ea == cur_q) other = eb;
    else if (eb == cur_q) other = ea;
    else hit_any = 1'b0;
  end

  assign p_ok     = XW'(anc_rd) < XW'(n_act);
  assign k_last_b = (k_q == KW'(LIFT_LEVELS - 2));
  assign k_next   = k_q + KW'(1);

  assign flags_o.op          = op_q;
  assign flags_o.ready       = ready_q;
  assign flags_o.node_bad    = (XW'(a_q) >= XW'(n_act)) || (XW'(b_q) >= XW'(n_act));
  assign flags_o.root_bad    = XW'(root_q) >= XW'(n_act);
  assign flags_o.v_last      = (XW'(v_q) + XW'(1)) == XW'(n_act);
  assign flags_o.q_empty     = (head_q == tail_q);
  assign flags_o.e_done      = (e_q == edge_total_q);
  assign flags_o.edge_hit    = hit_any && (XW'(other) < XW'(n_act));
  assign flags_o.p_ok        = p_ok;
  assign flags_o.lvl_done    = flags_o.v_last && k_last_b;
  assign flags_o.one_level   = (LIFT_LEVELS == 1);
  assign flags_o.q_unreached = !(ok_q && reached_rd);
  assign flags_o.diff_bit    = diff_q[0];
  assign flags_o.k_top       = (k_q == KW'(LIFT_LEVELS - 1));
  assign flags_o.k_zero      = (k_q == '0);
  assign flags_o.u_eq_w      = (u_q == w_q);

  assign adv = (cmd_i.uop == U_LWR) || ((cmd_i.uop == U_LRD2) && !p_ok);

  // memory address and write selection
  always_comb begin
    edge_we    = 1'b0;
    queue_we   = 1'b0;
    queue_wa   = tail_q[NW-1:0];
    queue_wd   = other_q;
    queue_ra   = head_q[NW-1:0];
    depth_we   = 1'b0;
    depth_wa   = other_q;
    depth_wd   = cdep_q + NW'(1);
    depth_ra   = queue_rd;
    reached_we = 1'b0;
    reached_wa = other_q;
    reached_wd = 1'b1;
    reached_ra = other;
    anc_we     = 1'b0;
    anc_wa     = {KW'(0), other_q};
    anc_wd     = CW'(cur_q);
    anc_ra     = {k_q, v_q};
    case (cmd_i.uop)
      U_ADD: begin
        edge_we = !flags_o.node_bad && (edge_total_q != NW'(EDGE_CAP));
      end
      U_CLR: begin
        depth_we   = 1'b1;
        depth_wa   = v_q;
        depth_wd   = '0;
        reached_we = 1'b1;
        reached_wa = v_q;
        reached_wd = 1'b0;
        anc_we     = 1'b1;
        anc_wa     = {KW'(0), v_q};
        anc_wd     = NO_ANC;
      end
      U_SEED: begin
        reached_we = 1'b1;
        reached_wa = root;
        queue_we   = 1'b1;
        queue_wa   = '0;
        queue_wd   = root;
      end
      U_RCHK: begin
        reached_we = !reached_rd;
        depth_we   = !reached_rd;
        anc_we     = !reached_rd;
        queue_we   = !reached_rd;
      end
      U_LRD2: begin
        anc_ra = {k_q, NW'(anc_rd)};
        anc_we = !p_ok;
        anc_wa = {k_next, v_q};
        anc_wd = NO_ANC;
      end
      U_LWR: begin
        anc_we = 1'b1;
        anc_wa = {k_next, v_q};
        anc_wd = anc_rd;
      end
      U_QRA:  reached_ra = node_a;
      U_QRB:  reached_ra = node_b;
      U_QDA:  depth_ra = node_a;
      U_QDB:  depth_ra = node_b;
      U_LIFT: anc_ra = {k_q, w_q};
      U_JRU:  anc_ra = {k_q, u_q};
      U_JRV:  anc_ra = {k_q, w_q};
      U_PAR:  anc_ra = {KW'(0), u_q};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_total_q] <= {node_a, node_b};
    edge_rd <= edge_mem[e_q];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk_i) begin
    if (depth_we) depth_mem[depth_wa] <= depth_wd;
    depth_rd <= depth_mem[depth_ra];
  end

  always_ff @(posedge clk_i) begin
    if (reached_we) reached_mem[reached_wa] <= reached_wd;
    reached_rd <= reached_mem[reached_ra];
  end

  always_ff @(posedge clk_i) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    anc_rd <= anc_mem[anc_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q     <= NODE_COUNT_RST;
      root_q       <= '0;
      edge_total_q <= '0;
      ready_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_NODE_COUNT) begin
          ncount_q <= cfg_data_i;
          ready_q  <= 1'b0;
        end else if (cfg_idx_i == REG_ROOT_NODE) begin
          root_q  <= cfg_data_i[NODE_W-1:0];
          ready_q <= 1'b0;
        end
      end
      if (edge_we) begin
        edge_total_q <= edge_total_q + NW'(1);
        ready_q      <= 1'b0;
      end
      if (cmd_i.uop == U_BCHK) ready_q <= 1'b0;
      if (cmd_i.uop == U_BDONE) ready_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q      <= operation_i;
      a_q       <= node_a_i;
      b_q       <= node_b_i;
      res_anc_q <= '0;
      res_st_q  <= ST_OK;
    end
    if (cmd_i.load) begin
      ancestor_o <= res_anc_q;
      status_o   <= res_st_q;
    end
    if (adv) begin
      if (flags_o.v_last) begin
        v_q <= '0;
        k_q <= k_next;
      end else begin
        v_q <= v_q + NW'(1);
      end
    end
    case (cmd_i.uop)
      U_ADD: begin
        if (flags_o.node_bad) res_st_q <= ST_NODE;
        else if (edge_total_q == NW'(EDGE_CAP)) res_st_q <= ST_FULL;
      end
      U_BCHK: begin
        if (flags_o.root_bad) res_st_q <= ST_NODE;
        v_q <= '0;
      end
      U_CLR: v_q <= v_q + NW'(1);
      U_SEED: begin
        head_q <= '0;
        tail_q <= CW'(1);
        v_q    <= '0;
        k_q    <= '0;
      end
      U_POP: if (!flags_o.q_empty) head_q <= head_q + CW'(1);
      U_CUR: begin
        cur_q <= queue_rd;
        e_q   <= '0;
      end
      U_DEP: cdep_q <= depth_rd;
      U_EDGE2: begin
        other_q <= other;
        e_q     <= e_q + NW'(1);
      end
      U_RCHK: if (!reached_rd) tail_q <= tail_q + CW'(1);
      U_QCHK: begin
        if (!ready_q) res_st_q <= ST_NOTB;
        else if (flags_o.node_bad) res_st_q <= ST_NODE;
      end
      U_QRB: ok_q <= reached_rd;
      U_QDA: if (flags_o.q_unreached) res_st_q <= ST_NODE;
      U_QDB: da_q <= depth_rd;
      U_QSWAP: begin
        k_q <= '0;
        if (da_q > depth_rd) begin
          u_q    <= node_b;
          w_q    <= node_a;
          diff_q <= da_q - depth_rd;
        end else begin
          u_q    <= node_a;
          w_q    <= node_b;
          diff_q <= depth_rd - da_q;
        end
      end
      U_LIFT: begin
        if (!diff_q[0]) begin
          k_q    <= k_next;
          diff_q <= diff_q >> 1;
        end
      end
      U_LIFTW: begin
        if (anc_rd < NO_ANC) w_q <= NW'(anc_rd);
        k_q    <= k_next;
        diff_q <= diff_q >> 1;
      end
      U_TEST: begin
        if (u_q == w_q) res_anc_q <= NODE_W'(u_q);
        k_q <= KW'(LIFT_LEVELS - 1);
      end
      U_JRV: pu_q <= anc_rd;
      U_JCMP: begin
        if ((pu_q != anc_rd) && (pu_q < NO_ANC) && (anc_rd < NO_ANC)) begin
          u_q <= NW'(pu_q);
          w_q <= NW'(anc_rd);
        end
        k_q <= k_q - KW'(1);
      end
      U_PARW: res_anc_q <= (anc_rd < NO_ANC) ? NODE_W'(anc_rd) : '0;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/lowest_common_ancestor_lifting.sv @@
// Build: clears the first n node entries, walks the E stored edges for
// each reached node from the root, then fills each lift level for every
// node. Query: lifts the deeper node to the same depth, then lifts both.
// One item in flight at a time. Reset clears state, root, edge count and
// the built flag and sets the node count to 1024; memories are written
// before use, the build clears its first n entries itself.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Binary-lifting LCA engine: edge adds, table build, ancestor queries.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lcal_cfg_if.sink    cfg_i,
  lcal_in_if.sink     in_i,
  lcal_out_if.source  out_o
);
  import lcal_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  assign cfg_i.ready = 1'b1;

  lcal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  lcal_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .operation_i (in_i.operation),
    .node_a_i    (in_i.node_a),
    .node_b_i    (in_i.node_b),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .ancestor_o  (out_o.ancestor),
    .status_o    (out_o.status)
  );

endmodule
`default_nettype wire
